### rtl/b64d_pkg.sv
// Shared types, class codes and the character lookup of the base64 decoder.
`default_nettype none

package b64d_pkg;

  // Queue depth between front and back.
  localparam int QueueDepth = 2;

  // Character classes found by the front part
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_BLANK   = 3'd0;  // space, tab, CR
  localparam kind_t KIND_NEWLINE = 3'd1;  // LF
  localparam kind_t KIND_PAD     = 3'd2;  // '='
  localparam kind_t KIND_SEXTET  = 3'd3;  // base64 alphabet
  localparam kind_t KIND_OTHER   = 3'd4;  // anything else

  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharLf      = 8'h0A;
  localparam logic [7:0] CharCr      = 8'h0D;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharSlash   = 8'h2F;
  localparam logic [7:0] CharDigit0  = 8'h30;
  localparam logic [7:0] CharDigit9  = 8'h39;
  localparam logic [7:0] CharEquals  = 8'h3D;
  localparam logic [7:0] CharUpperA  = 8'h41;
  localparam logic [7:0] CharUpperZ  = 8'h5A;
  localparam logic [7:0] CharLowerA  = 8'h61;
  localparam logic [7:0] CharLowerZ  = 8'h7A;

  // Input item: one character
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } char_item_t;

  // Result item: up to three decoded bytes
  typedef struct packed {
    logic [23:0] data_word;
    logic [1:0]  byte_count;
    logic        end_of_stream;
  } word_item_t;

  // Classified character as it travels through the queue
  typedef struct packed {
    kind_t      kind;
    logic [5:0] sextet;
    logic       last;
  } class_item_t;

  // Map one character to its class and sextet value.
  function automatic class_item_t classify(input char_item_t item);
    class_item_t res;
    logic [7:0]  ch;
    ch         = item.char_code;
    res.kind   = KIND_OTHER;
    res.sextet = 6'd0;
    res.last   = item.end_of_input;
    if (ch == CharSpace || ch == CharTab || ch == CharCr) begin
      res.kind = KIND_BLANK;
    end else if (ch == CharLf) begin
      res.kind = KIND_NEWLINE;
    end else if (ch == CharEquals) begin
      res.kind = KIND_PAD;
    end else if (ch >= CharUpperA && ch <= CharUpperZ) begin
      res.kind   = KIND_SEXTET;
      res.sextet = 6'(ch - CharUpperA);
    end else if (ch >= CharLowerA && ch <= CharLowerZ) begin
      res.kind   = KIND_SEXTET;
      res.sextet = 6'(ch - CharLowerA + 8'd26);
    end else if (ch >= CharDigit0 && ch <= CharDigit9) begin
      res.kind   = KIND_SEXTET;
      res.sextet = 6'(ch - CharDigit0 + 8'd52);
    end else if (ch == CharPlus) begin
      res.kind   = KIND_SEXTET;
      res.sextet = 6'd62;
    end else if (ch == CharSlash) begin
      res.kind   = KIND_SEXTET;
      res.sextet = 6'd63;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/b64d_front.sv
// Front part: accepts characters and classifies them into the queue.
`default_nettype none

module b64d_front (
  input  wire b64d_pkg::char_item_t  char_item,
  input  wire                        char_valid,
  output logic                       char_ready,
  output logic                       push,
  output b64d_pkg::class_item_t      push_item,
  input  wire                        queue_full
);

  // Take a character whenever the queue has room
  assign char_ready = !queue_full;
  assign push       = char_valid && !queue_full;

  // Classify the character on its way in
  assign push_item  = b64d_pkg::classify(char_item);

endmodule

`default_nettype wire

### rtl/b64d_queue.sv
// Short queue of classified characters between front and back.
`default_nettype none

module b64d_queue #(
  parameter int Depth = b64d_pkg::QueueDepth
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         push,
  input  wire b64d_pkg::class_item_t  push_item,
  output logic                        full,
  input  wire                         pop,
  output logic                        not_empty,
  output b64d_pkg::class_item_t       head_item
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  b64d_pkg::class_item_t entries [Depth];
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] count;

  assign full      = (count == CW'(Depth));
  assign not_empty = (count != '0);
  assign head_item = entries[head];

  // Store at the tail on push
  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == AW'(Depth - 1)) ? '0 : tail + AW'(1);
      end
      if (pop) begin
        head <= (head == AW'(Depth - 1)) ? '0 : head + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/b64d_back.sv
// Back part: group state, sextet packing and the result register.
`default_nettype none

module b64d_back (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         not_empty,
  input  wire b64d_pkg::class_item_t  head_item,
  output logic                        pop,
  output logic                        word_valid,
  input  wire                         word_ready,
  output b64d_pkg::word_item_t        word_item
);

  logic [23:0] group_bytes;
  logic [1:0]  group_position;
  logic        skip_line;
  logic        dead_after_pad;

  logic [23:0] group_bytes_next;
  logic [1:0]  group_position_next;
  logic        skip_line_next;
  logic        dead_after_pad_next;
  logic        emit;
  logic [23:0] flush_word;
  b64d_pkg::word_item_t result;

  // Take an item when the result register is free or being drained
  assign pop = not_empty && (!word_valid || word_ready);

  // Update group state for one classified character
  always_comb begin
    group_bytes_next    = group_bytes;
    group_position_next = group_position;
    skip_line_next      = skip_line;
    dead_after_pad_next = dead_after_pad;
    emit                = 1'b0;
    if (head_item.kind == b64d_pkg::KIND_BLANK) begin
      emit = 1'b0;
    end else if (head_item.kind == b64d_pkg::KIND_NEWLINE) begin
      skip_line_next = 1'b0;
    end else if (skip_line) begin
      emit = 1'b0;
    end else if (head_item.kind == b64d_pkg::KIND_PAD) begin
      if (!dead_after_pad) begin
        if (group_position == 2'd0) begin
          dead_after_pad_next = 1'b1;
        end else begin
          group_position_next = group_position - 2'd1;
        end
      end
      skip_line_next = 1'b1;
    end else if (head_item.kind != b64d_pkg::KIND_SEXTET) begin
      skip_line_next = 1'b1;
    end else if (!dead_after_pad) begin
      unique case (group_position)
        2'd0: begin
          group_bytes_next[23:18] = group_bytes[23:18] | head_item.sextet;
          group_position_next     = 2'd1;
        end
        2'd1: begin
          group_bytes_next[17:16] = group_bytes[17:16] | head_item.sextet[5:4];
          group_bytes_next[15:12] = group_bytes[15:12] | head_item.sextet[3:0];
          group_position_next     = 2'd2;
        end
        2'd2: begin
          group_bytes_next[11:8] = group_bytes[11:8] | head_item.sextet[5:2];
          group_bytes_next[7:6]  = group_bytes[7:6] | head_item.sextet[1:0];
          group_position_next    = 2'd3;
        end
        default: begin
          group_bytes_next[5:0] = group_bytes[5:0] | head_item.sextet;
          emit                  = 1'b1;
        end
      endcase
    end
  end

  // Keep only the valid leading bytes of a partial group
  always_comb begin
    unique case (group_position_next)
      2'd1:    flush_word = {group_bytes_next[23:16], 16'h0000};
      2'd2:    flush_word = {group_bytes_next[23:8], 8'h00};
      2'd3:    flush_word = group_bytes_next;
      default: flush_word = 24'h000000;
    endcase
  end

  // Build the result for this character
  always_comb begin
    result.end_of_stream = head_item.last;
    if (emit) begin
      result.data_word  = group_bytes_next;
      result.byte_count = 2'd3;
    end else if (!dead_after_pad_next) begin
      result.data_word  = flush_word;
      result.byte_count = group_position_next;
    end else begin
      result.data_word  = 24'h000000;
      result.byte_count = 2'd0;
    end
  end

  // Commit state; a full group or the last character clears it
  always_ff @(posedge clk) begin
    if (rst) begin
      group_bytes    <= '0;
      group_position <= '0;
      skip_line      <= 1'b0;
      dead_after_pad <= 1'b0;
    end else if (pop) begin
      if (head_item.last) begin
        group_bytes    <= '0;
        group_position <= '0;
        skip_line      <= 1'b0;
        dead_after_pad <= 1'b0;
      end else begin
        group_bytes    <= emit ? 24'h000000 : group_bytes_next;
        group_position <= emit ? 2'd0 : group_position_next;
        skip_line      <= skip_line_next;
        dead_after_pad <= dead_after_pad_next;
      end
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (pop && (emit || head_item.last)) begin
      word_valid <= 1'b1;
    end else if (word_ready) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (emit || head_item.last)) begin
      word_item <= result;
    end
  end

endmodule

`default_nettype wire

### rtl/base64_line_tolerant_decoder.sv
// Top level of the line-tolerant base64 decoder.
//
//  channel | signals                              | moves
//  --------+--------------------------------------+-------------------------------
//  char    | char_valid, char_ready, char_item    | one character, end-of-input flag
//  word    | word_valid, word_ready, word_item    | up to 3 bytes, count, end flag
//
// One character per cycle sustained while word_ready does not stall; the queue
// between classifier and group logic is QueueDepth entries. A transferred
// character is written into the queue, and any result it produces is registered
// at the same edge that pops it from the queue.
// Reset (rst, synchronous) empties the queue and clears all group state.
// A stall on word_ready backs up through the result register and the queue.
`default_nettype none

module base64_line_tolerant_decoder #(
  parameter int QueueDepth = b64d_pkg::QueueDepth
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        char_valid,
  output logic                       char_ready,
  input  wire b64d_pkg::char_item_t  char_item,
  output logic                       word_valid,
  input  wire                        word_ready,
  output b64d_pkg::word_item_t       word_item
);

  logic                  push;
  b64d_pkg::class_item_t push_item;
  logic                  queue_full;
  logic                  pop;
  logic                  not_empty;
  b64d_pkg::class_item_t head_item;

  b64d_front u_front (
    .char_item  (char_item),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head_item (head_item)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .not_empty  (not_empty),
    .head_item  (head_item),
    .pop        (pop),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word_item  (word_item)
  );

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the line-tolerant base64 decoder.
`timescale 1ns / 100ps

module testbench;

  localparam int CycleLimit  = 400000;
  localparam int MaxReported = 10;
  localparam int RandomChars = 1600;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 char_valid = 1'b0;
  logic                 char_ready;
  b64d_pkg::char_item_t char_item  = '0;
  logic                 word_valid;
  logic                 word_ready = 1'b0;
  b64d_pkg::word_item_t word_item;

  // Decoder state as predicted from the accepted characters
  logic [23:0] acc_bits    = '0;
  logic [1:0]  sextet_slot = '0;
  logic        line_muted  = 1'b0;
  logic        pad_killed  = 1'b0;

  b64d_pkg::word_item_t decoded_words[$];

  int mismatches  = 0;
  int chars_sent  = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  int stall_left  = 0;
  bit sender_idle = 1'b0;
  bit recv_idle   = 1'b0;

  base64_line_tolerant_decoder DUT (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word_item  (word_item)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // Hold off the result channel in stalls of random length
  always @(posedge clk) begin
    if (recv_idle && stall_left == 0 && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 8);
    end
    if (stall_left > 0) begin
      stall_left--;
      word_ready <= 1'b0;
    end else begin
      word_ready <= 1'b1;
    end
  end

  // Class of a character; value holds the sextet for alphabet characters
  function automatic b64d_pkg::kind_t char_kind(input logic [7:0] code,
                                                output logic [5:0] value);
    b64d_pkg::kind_t kind;
    value = '0;
    kind  = b64d_pkg::KIND_OTHER;
    case (code)
      b64d_pkg::CharSpace, b64d_pkg::CharTab, b64d_pkg::CharCr: begin
        kind = b64d_pkg::KIND_BLANK;
      end
      b64d_pkg::CharLf:     kind = b64d_pkg::KIND_NEWLINE;
      b64d_pkg::CharEquals: kind = b64d_pkg::KIND_PAD;
      b64d_pkg::CharPlus: begin
        kind  = b64d_pkg::KIND_SEXTET;
        value = 6'd62;
      end
      b64d_pkg::CharSlash: begin
        kind  = b64d_pkg::KIND_SEXTET;
        value = 6'd63;
      end
      default: begin
        if (code >= b64d_pkg::CharUpperA && code <= b64d_pkg::CharUpperZ) begin
          kind  = b64d_pkg::KIND_SEXTET;
          value = 6'(code - b64d_pkg::CharUpperA);
        end else if (code >= b64d_pkg::CharLowerA && code <= b64d_pkg::CharLowerZ) begin
          kind  = b64d_pkg::KIND_SEXTET;
          value = 6'(code - b64d_pkg::CharLowerA + 8'd26);
        end else if (code >= b64d_pkg::CharDigit0 && code <= b64d_pkg::CharDigit9) begin
          kind  = b64d_pkg::KIND_SEXTET;
          value = 6'(code - b64d_pkg::CharDigit0 + 8'd52);
        end
      end
    endcase
    return kind;
  endfunction

  // Encode a sextet value as its alphabet character
  function automatic logic [7:0] alphabet_char(input logic [5:0] value);
    if (value < 6'd26) return b64d_pkg::CharUpperA + 8'(value);
    if (value < 6'd52) return b64d_pkg::CharLowerA + 8'(value - 6'd26);
    if (value < 6'd62) return b64d_pkg::CharDigit0 + 8'(value - 6'd52);
    if (value == 6'd62) return b64d_pkg::CharPlus;
    return b64d_pkg::CharSlash;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 2))
      0:       return b64d_pkg::CharSpace;
      1:       return b64d_pkg::CharTab;
      default: return b64d_pkg::CharCr;
    endcase
  endfunction

  // Advance the predicted state by one character and queue any decoded word
  task automatic decode_char(input b64d_pkg::char_item_t item);
    b64d_pkg::kind_t      kind;
    logic [5:0]           value;
    logic                 emitted;
    b64d_pkg::word_item_t word;
    kind    = char_kind(item.char_code, value);
    emitted = 1'b0;
    word    = '0;
    if (kind == b64d_pkg::KIND_NEWLINE) begin
      line_muted = 1'b0;
    end else if (kind != b64d_pkg::KIND_BLANK && !line_muted) begin
      if (kind == b64d_pkg::KIND_PAD) begin
        if (!pad_killed) begin
          if (sextet_slot == 2'd0) pad_killed = 1'b1;
          else sextet_slot = sextet_slot - 2'd1;
        end
        line_muted = 1'b1;
      end else if (kind == b64d_pkg::KIND_OTHER) begin
        line_muted = 1'b1;
      end else if (!pad_killed) begin
        case (sextet_slot)
          2'd0: acc_bits[23:18] = acc_bits[23:18] | value;
          2'd1: begin
            acc_bits[17:16] = acc_bits[17:16] | value[5:4];
            acc_bits[15:12] = acc_bits[15:12] | value[3:0];
          end
          2'd2: begin
            acc_bits[11:8] = acc_bits[11:8] | value[5:2];
            acc_bits[7:6]  = acc_bits[7:6] | value[1:0];
          end
          default: begin
            acc_bits[5:0]   = acc_bits[5:0] | value;
            word.data_word  = acc_bits;
            word.byte_count = 2'd3;
            emitted         = 1'b1;
            acc_bits        = '0;
          end
        endcase
        sextet_slot = sextet_slot + 2'd1;
      end
    end
    // Flush the partial group and clear everything on the last character
    if (item.end_of_input) begin
      if (!emitted && !pad_killed && sextet_slot != 2'd0) begin
        word.byte_count = sextet_slot;
        case (sextet_slot)
          2'd1:    word.data_word = {acc_bits[23:16], 16'h0000};
          2'd2:    word.data_word = {acc_bits[23:8], 8'h00};
          default: word.data_word = acc_bits;
        endcase
      end
      word.end_of_stream = 1'b1;
      acc_bits    = '0;
      sextet_slot = '0;
      line_muted  = 1'b0;
      pad_killed  = 1'b0;
      decoded_words.push_back(word);
    end else if (emitted) begin
      decoded_words.push_back(word);
    end
  endtask

  // Offer one character and hold it until the transfer; called at a rising edge
  task automatic send_char(input logic [7:0] code, input logic last);
    b64d_pkg::char_item_t item;
    logic                 took;
    item.char_code    = code;
    item.end_of_input = last;
    if (sender_idle && burst_left == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    char_valid <= 1'b1;
    char_item  <= item;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = char_ready;
      @(posedge clk);
    end
    decode_char(item);
    chars_sent++;
  endtask

  // Send a string; the final character optionally ends the stream
  task automatic send_text(input string text, input bit end_at_last);
    for (int i = 0; i < text.len(); i++) begin
      send_char(text[i], end_at_last && i == text.len() - 1);
    end
  endtask

  // Check each word transfer against the oldest prediction
  always @(negedge clk) begin
    b64d_pkg::word_item_t want;
    if (!rst && word_valid && word_ready) begin
      if (decoded_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("unexpected word: data %h count %0d end %b",
                   word_item.data_word, word_item.byte_count, word_item.end_of_stream);
        end
      end else begin
        want = decoded_words.pop_front();
        if (word_item.data_word !== want.data_word ||
            word_item.byte_count !== want.byte_count ||
            word_item.end_of_stream !== want.end_of_stream) begin
          mismatches++;
          if (mismatches <= MaxReported) begin
            $display("word mismatch: expected %h %0d %b, got %h %0d %b",
                     want.data_word, want.byte_count, want.end_of_stream,
                     word_item.data_word, word_item.byte_count, word_item.end_of_stream);
          end
        end
      end
    end
  end

  // All-ones sextets with blanks between them, no idling on either side
  task automatic test_full_groups();
    sender_idle = 1'b0;
    recv_idle   = 1'b0;
    send_text("/ /\t/\r/", 1'b0);
  endtask

  // Illegal and non-ASCII characters mute the line until LF
  task automatic test_skip_rules();
    sender_idle = 1'b1;
    recv_idle   = 1'b0;
    send_text("*Q\n", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(b64d_pkg::CharLf, 1'b0);
  endtask

  // Pad mid-group keeps old bits, pad while muted is dropped, pad at group
  // start kills decoding up to the end of the stream
  task automatic test_padding();
    sender_idle = 1'b0;
    recv_idle   = 1'b1;
    send_text("TW==\nz9", 1'b1);
    send_text("=\nB", 1'b1);
  endtask

  // End on a full all-zero group, on a partial group and at group start
  task automatic test_stream_end();
    sender_idle = 1'b1;
    recv_idle   = 1'b1;
    send_text("AAAA", 1'b1);
    send_text("Qg", 1'b1);
    send_text(" ", 1'b1);
  endtask

  // Mostly well-formed lines with random content, plus noise and early ends
  task automatic test_random_text(input int target);
    int first;
    int pick;
    int groups;
    int tail;
    first = chars_sent;
    while (chars_sent - first < target) begin
      sender_idle = $urandom_range(0, 3) != 0;
      recv_idle   = $urandom_range(0, 3) != 0;
      pick        = $urandom_range(0, 99);
      if (pick < 75) begin
        groups = $urandom_range(0, 6);
        tail   = $urandom_range(0, 3);
        for (int i = 0; i < groups * 4 + tail; i++) begin
          if ($urandom_range(0, 9) == 0) send_char(blank_char(), 1'b0);
          send_char(alphabet_char(6'($urandom_range(0, 63))), $urandom_range(0, 49) == 0);
        end
        // Pad the tail; sometimes wrongly, or at group start
        if (tail == 2) send_text("==", 1'b0);
        else if (tail == 3) send_text("=", 1'b0);
        else if ($urandom_range(0, 9) == 0) send_text("=", 1'b0);
        send_char(b64d_pkg::CharLf, $urandom_range(0, 9) == 0);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6)) begin
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
        end
      end else begin
        send_char(alphabet_char(6'($urandom_range(0, 63))), 1'b1);
      end
    end
    send_char(b64d_pkg::CharLf, 1'b1);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_full_groups();
    test_skip_rules();
    test_padding();
    test_stream_end();
    test_random_text(RandomChars);
    char_valid <= 1'b0;
    recv_idle = 1'b0;
    // Drain outstanding words, then watch for stray ones
    while (decoded_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && decoded_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
